[hw/rtl/pime_pkg.sv]
// Shared types, constants and helpers for the polynomial identity evaluator.
// Used by every RTL file of the block except pime_ram; depends on nothing else.

package pime_pkg;

    localparam int NUM_POINTS = 32;
    localparam int IDX_W      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int PADDR_W    = $clog2(2 * NUM_POINTS);
    localparam int MOD_W      = 30;
    localparam int COEF_W     = 32;
    localparam int EXP_W      = 32;
    localparam int BIT_W      = $clog2(EXP_W);

    localparam logic [MOD_W-1:0] MODULUS_RESET = 30'd1000000007;
    localparam logic [MOD_W-1:0] MODULUS_MIN   = 30'd2;

    localparam logic [2:0] ACT_LOAD    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_TERM    = 3'd2;
    localparam logic [2:0] ACT_CLOSE   = 3'd3;
    localparam logic [2:0] ACT_COMPARE = 3'd4;

    typedef struct packed {
        logic [2:0]        action;
        logic              side;
        logic [4:0]        point_index;
        logic [MOD_W-1:0]  point_value;
        logic              coef_negative;
        logic [COEF_W-1:0] coef_magnitude;
        logic [EXP_W-1:0]  exponent;
    } s_item_t;

    typedef struct packed {
        logic answer_valid;
        logic identical;
    } m_item_t;

    typedef struct packed {
        logic              start;
        logic [MOD_W-1:0]  a;
        logic [COEF_W-1:0] b;
        logic [MOD_W-1:0]  m;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] result;
    } mul_rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_COEF,
        ST_PT_RD,
        ST_PT_RED,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_TERM,
        ST_SUM_RED,
        ST_SUM_WR,
        ST_CL_RD,
        ST_CL_RED,
        ST_CL_MUL,
        ST_CMP_RD,
        ST_CMP_RED,
        ST_DONE
    } state_t;

    function automatic logic [PADDR_W-1:0] prod_addr(logic side, logic [IDX_W-1:0] idx);
        return PADDR_W'(idx) + (side ? PADDR_W'(NUM_POINTS) : PADDR_W'(0));
    endfunction

endpackage

[hw/rtl/poly_identity_mod_eval_unit.sv]
// Top level of the polynomial identity evaluator: modulus register and wiring.
// Depends on pime_pkg, pime_ram, pime_mulmod and pime_seq.
//
// The block evaluates two polynomials, each a product of factors that are sums
// of terms, at up to NUM_POINTS stored points modulo a configured prime.
// Input transactions on the s_ channel load a point, start a polynomial, add a
// term, close a factor or compare both sides. Every input transaction yields
// exactly one output transaction on the m_ channel; only a compare sets
// answer_valid, and identical then reports agreement at every point.
// The cfg channel writes the modulus and is to be used only while the block
// is idle; the block itself does not enforce this. Each item is handled by
// one bit-serial modular multiplier, which paces terms, closes and compares.
// s_ready is high only between items. After reset a clearing pass initializes
// the stores with s_ready low. A stalled receiver holds the result in the
// output register; the next item is still taken and waits at its end for the
// slot.

module poly_identity_mod_eval_unit
    import pime_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [MOD_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  s_item_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output m_item_t          m_data
);

    logic [MOD_W-1:0]   modulus_reg;
    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;
    logic               pt_we;
    logic [IDX_W-1:0]   pt_waddr;
    logic [MOD_W-1:0]   pt_wdata;
    logic [IDX_W-1:0]   pt_raddr;
    logic [MOD_W-1:0]   pt_rdata;
    logic               sum_we;
    logic [IDX_W-1:0]   sum_waddr;
    logic [MOD_W-1:0]   sum_wdata;
    logic [IDX_W-1:0]   sum_raddr;
    logic [MOD_W-1:0]   sum_rdata;
    logic               prod_we;
    logic [PADDR_W-1:0] prod_waddr;
    logic [MOD_W-1:0]   prod_wdata;
    logic [PADDR_W-1:0] prod_raddr;
    logic [MOD_W-1:0]   prod_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_valid) begin
            modulus_reg <= cfg_wdata;
        end
    end

    pime_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .modulus    (modulus_reg),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp),
        .pt_we      (pt_we),
        .pt_waddr   (pt_waddr),
        .pt_wdata   (pt_wdata),
        .pt_raddr   (pt_raddr),
        .pt_rdata   (pt_rdata),
        .sum_we     (sum_we),
        .sum_waddr  (sum_waddr),
        .sum_wdata  (sum_wdata),
        .sum_raddr  (sum_raddr),
        .sum_rdata  (sum_rdata),
        .prod_we    (prod_we),
        .prod_waddr (prod_waddr),
        .prod_wdata (prod_wdata),
        .prod_raddr (prod_raddr),
        .prod_rdata (prod_rdata)
    );

    pime_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    pime_ram #(.WIDTH(MOD_W), .DEPTH(NUM_POINTS)) u_points (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    pime_ram #(.WIDTH(MOD_W), .DEPTH(NUM_POINTS)) u_sums (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    pime_ram #(.WIDTH(MOD_W), .DEPTH(2 * NUM_POINTS)) u_products (
        .aclk  (aclk),
        .we    (prod_we),
        .waddr (prod_waddr),
        .wdata (prod_wdata),
        .raddr (prod_raddr),
        .rdata (prod_rdata)
    );

    // An accepted transaction always takes the sequencer out of its idle state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted back to back");

    // Only a compare can report agreement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.identical) |-> m_data.answer_valid)
        else $error("identical set on a non-compare result");

    // The multiplier is never restarted in the cycle it finishes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> !mul_req.start)
        else $error("multiplier start collides with completion");

endmodule

[hw/rtl/pime_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the point, factor sum and product stores.

module pime_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/pime_mulmod.sv]
// Bit-serial modular multiplier computing (a * b) mod m, one bit of b per cycle.
// Depends on pime_pkg; operand a must already be below m.

module pime_mulmod
    import pime_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [MOD_W-1:0]  acc_reg, acc_next;
    logic [MOD_W-1:0]  a_reg;
    logic [COEF_W-1:0] b_reg;
    logic [MOD_W-1:0]  m_reg;
    logic [BIT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MOD_W:0]    dbl;
    logic [MOD_W:0]    dbl_red;
    logic [MOD_W:0]    sum;

    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum     = dbl_red + (b_reg[COEF_W-1] ? {1'b0, a_reg} : '0);
        acc_next = (sum >= {1'b0, m_reg}) ? MOD_W'(sum - {1'b0, m_reg}) : MOD_W'(sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == BIT_W'(COEF_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (req.start) begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
            m_reg   <= req.m;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[COEF_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

[hw/rtl/pime_seq.sv]
// Sequencer of the evaluator: handshakes, per-point loops and store accesses.
// Depends on pime_pkg; drives the shared pime_mulmod unit and three pime_ram stores.

module pime_seq
    import pime_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  s_item_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output m_item_t            m_data,
    input  logic [MOD_W-1:0]   modulus,
    output mul_req_t           mul_req,
    input  mul_rsp_t           mul_rsp,
    output logic               pt_we,
    output logic [IDX_W-1:0]   pt_waddr,
    output logic [MOD_W-1:0]   pt_wdata,
    output logic [IDX_W-1:0]   pt_raddr,
    input  logic [MOD_W-1:0]   pt_rdata,
    output logic               sum_we,
    output logic [IDX_W-1:0]   sum_waddr,
    output logic [MOD_W-1:0]   sum_wdata,
    output logic [IDX_W-1:0]   sum_raddr,
    input  logic [MOD_W-1:0]   sum_rdata,
    output logic               prod_we,
    output logic [PADDR_W-1:0] prod_waddr,
    output logic [MOD_W-1:0]   prod_wdata,
    output logic [PADDR_W-1:0] prod_raddr,
    input  logic [MOD_W-1:0]   prod_rdata
);

    state_t             state_reg, state_next;
    s_item_t            item_reg, item_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PADDR_W-1:0] clr_reg, clr_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [EXP_W-1:0]   exp_reg, exp_next;
    logic [MOD_W-1:0]   acc_reg, acc_next;
    logic [MOD_W-1:0]   base_reg, base_next;
    logic [MOD_W-1:0]   coef_reg, coef_next;
    logic [MOD_W-1:0]   tmp_reg, tmp_next;
    logic               same_reg, same_next;
    logic               cmp_side_reg, cmp_side_next;
    logic               issued_reg, issued_next;
    logic               m_valid_reg, m_valid_next;
    m_item_t            out_reg, out_next;
    logic [MOD_W-1:0]   m_eff;
    logic [MOD_W:0]     sum_add;
    logic [MOD_W-1:0]   sum_red;
    logic               idx_last;
    logic               go;
    logic               done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        bit_reg      <= bit_next;
        exp_reg      <= exp_next;
        acc_reg      <= acc_next;
        base_reg     <= base_next;
        coef_reg     <= coef_next;
        tmp_reg      <= tmp_next;
        same_reg     <= same_next;
        cmp_side_reg <= cmp_side_next;
        out_reg      <= out_next;
    end

    always_comb begin
        m_eff    = (modulus < MODULUS_MIN) ? MODULUS_MIN : modulus;
        sum_add  = {1'b0, tmp_reg} + {1'b0, acc_reg};
        sum_red  = (sum_add >= {1'b0, m_eff}) ? MOD_W'(sum_add - {1'b0, m_eff})
                                              : MOD_W'(sum_add);
        idx_last = (idx_reg == IDX_W'(NUM_POINTS - 1));
        go       = !issued_reg;
        done     = mul_rsp.done;

        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        clr_next      = clr_reg;
        bit_next      = bit_reg;
        exp_next      = exp_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        coef_next     = coef_reg;
        tmp_next      = tmp_reg;
        same_next     = same_reg;
        cmp_side_next = cmp_side_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;

        mul_req.start = 1'b0;
        mul_req.a     = MOD_W'(1);
        mul_req.b     = '0;
        mul_req.m     = m_eff;

        pt_we      = 1'b0;
        pt_waddr   = IDX_W'(s_data.point_index);
        pt_wdata   = s_data.point_value;
        sum_we     = 1'b0;
        sum_waddr  = idx_reg;
        sum_wdata  = '0;
        prod_we    = 1'b0;
        prod_waddr = prod_addr(item_reg.side, idx_reg);
        prod_wdata = MOD_W'(1);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                prod_we    = 1'b1;
                prod_waddr = clr_reg;
                sum_we     = (clr_reg < PADDR_W'(NUM_POINTS));
                sum_waddr  = IDX_W'(clr_reg);
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == PADDR_W'(2 * NUM_POINTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next     = s_data;
                    idx_next      = '0;
                    cmp_side_next = 1'b0;
                    same_next     = (s_data.action == ACT_COMPARE);
                    unique case (s_data.action)
                        ACT_LOAD: begin
                            pt_we      = (32'(s_data.point_index) < NUM_POINTS);
                            state_next = ST_DONE;
                        end
                        ACT_START:   state_next = ST_INIT;
                        ACT_TERM:    state_next = ST_COEF;
                        ACT_CLOSE:   state_next = ST_CL_RD;
                        ACT_COMPARE: state_next = ST_CMP_RD;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_INIT: begin
                prod_we  = 1'b1;
                sum_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_COEF: begin
                mul_req.start = go;
                mul_req.b     = item_reg.coef_magnitude;
                if (done) begin
                    coef_next = (item_reg.coef_negative && mul_rsp.result != '0)
                              ? m_eff - mul_rsp.result : mul_rsp.result;
                    state_next = ST_PT_RD;
                end
            end
            ST_PT_RD: begin
                acc_next   = MOD_W'(1);
                exp_next   = item_reg.exponent;
                bit_next   = '0;
                state_next = ST_PT_RED;
            end
            ST_PT_RED: begin
                mul_req.start = go;
                mul_req.b     = COEF_W'(pt_rdata);
                if (done) begin
                    base_next  = mul_rsp.result;
                    state_next = ST_POW_MUL;
                end
            end
            ST_POW_MUL: begin
                if (exp_reg[0]) begin
                    mul_req.start = go;
                    mul_req.a     = acc_reg;
                    mul_req.b     = COEF_W'(base_reg);
                    if (done) begin
                        acc_next   = mul_rsp.result;
                        state_next = ST_POW_SQR;
                    end
                end else begin
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR: begin
                mul_req.start = go;
                mul_req.a     = base_reg;
                mul_req.b     = COEF_W'(base_reg);
                if (done) begin
                    base_next = mul_rsp.result;
                    exp_next  = exp_reg >> 1;
                    bit_next  = bit_reg + 1'b1;
                    state_next = (bit_reg == BIT_W'(EXP_W - 1)) ? ST_TERM : ST_POW_MUL;
                end
            end
            ST_TERM: begin
                mul_req.start = go;
                mul_req.a     = coef_reg;
                mul_req.b     = COEF_W'(acc_reg);
                if (done) begin
                    acc_next   = mul_rsp.result;
                    state_next = ST_SUM_RED;
                end
            end
            ST_SUM_RED: begin
                mul_req.start = go;
                mul_req.b     = COEF_W'(sum_rdata);
                if (done) begin
                    tmp_next   = mul_rsp.result;
                    state_next = ST_SUM_WR;
                end
            end
            ST_SUM_WR: begin
                sum_we     = 1'b1;
                sum_wdata  = sum_red;
                idx_next   = idx_reg + 1'b1;
                state_next = idx_last ? ST_DONE : ST_PT_RD;
            end
            ST_CL_RD: begin
                state_next = ST_CL_RED;
            end
            ST_CL_RED: begin
                mul_req.start = go;
                mul_req.b     = COEF_W'(prod_rdata);
                if (done) begin
                    tmp_next   = mul_rsp.result;
                    state_next = ST_CL_MUL;
                end
            end
            ST_CL_MUL: begin
                mul_req.start = go;
                mul_req.a     = tmp_reg;
                mul_req.b     = COEF_W'(sum_rdata);
                if (done) begin
                    prod_we    = 1'b1;
                    prod_wdata = mul_rsp.result;
                    sum_we     = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = idx_last ? ST_DONE : ST_CL_RD;
                end
            end
            ST_CMP_RD: begin
                state_next = ST_CMP_RED;
            end
            ST_CMP_RED: begin
                mul_req.start = go;
                mul_req.b     = COEF_W'(prod_rdata);
                if (done) begin
                    if (!cmp_side_reg) begin
                        tmp_next      = mul_rsp.result;
                        cmp_side_next = 1'b1;
                        state_next    = ST_CMP_RD;
                    end else begin
                        if (mul_rsp.result != tmp_reg) begin
                            same_next = 1'b0;
                        end
                        cmp_side_next = 1'b0;
                        idx_next      = idx_reg + 1'b1;
                        state_next    = idx_last ? ST_DONE : ST_CMP_RD;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.answer_valid = (item_reg.action == ACT_COMPARE);
                    out_next.identical    = same_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (mul_req.start) begin
            issued_next = 1'b1;
        end else if (done) begin
            issued_next = 1'b0;
        end else begin
            issued_next = issued_reg;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = out_reg;
    assign pt_raddr   = idx_reg;
    assign sum_raddr  = idx_reg;
    assign prod_raddr = prod_addr((item_reg.action == ACT_COMPARE) ? cmp_side_reg
                                                                   : item_reg.side, idx_reg);

endmodule

[tb/pime_identity_checker.sv]
// Transaction checker for the polynomial identity evaluator: tracks modulus writes,
// predicts one answer per input transaction and compares it with the output channel.
// Depends on pime_pkg for the payload types and action codes.
`timescale 1ns / 100ps

module pime_identity_checker
    import pime_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [MOD_W-1:0] cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  s_item_t          s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  m_item_t          m_data,
    output int               errors,
    output int               answers_pending
);

    logic [MOD_W-1:0] modulus;
    logic [MOD_W-1:0] points [NUM_POINTS];
    logic [MOD_W-1:0] sums [NUM_POINTS];
    logic [MOD_W-1:0] prods [2][NUM_POINTS];
    m_item_t          answers_due [$];

    function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                                longint unsigned m);
        return ((a % m) * (b % m)) % m;
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned base, logic [EXP_W-1:0] e,
                                                longint unsigned m);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1 % m;
        sq  = base % m;
        for (int k = 0; k < EXP_W; k++) begin
            if (e[k]) begin
                acc = mul_mod(acc, sq, m);
            end
            sq = mul_mod(sq, sq, m);
        end
        return acc;
    endfunction

    task automatic predict_answer(input s_item_t it);
        longint unsigned m;
        longint unsigned c;
        longint unsigned t;
        m_item_t         ans;
        m   = (modulus < MODULUS_MIN) ? 64'(MODULUS_MIN) : 64'(modulus);
        ans = '0;
        case (it.action)
            ACT_LOAD: begin
                if (it.point_index < NUM_POINTS) begin
                    points[it.point_index] = it.point_value;
                end
            end
            ACT_START: begin
                for (int i = 0; i < NUM_POINTS; i++) begin
                    prods[it.side][i] = MOD_W'(1);
                    sums[i] = '0;
                end
            end
            ACT_TERM: begin
                c = 64'(it.coef_magnitude) % m;
                if (it.coef_negative && c != 0) begin
                    c = m - c;
                end
                for (int i = 0; i < NUM_POINTS; i++) begin
                    t = mul_mod(c, pow_mod(64'(points[i]), it.exponent, m), m);
                    sums[i] = MOD_W'(((64'(sums[i]) % m) + t) % m);
                end
            end
            ACT_CLOSE: begin
                for (int i = 0; i < NUM_POINTS; i++) begin
                    prods[it.side][i] = MOD_W'(mul_mod(64'(prods[it.side][i]),
                                                       64'(sums[i]), m));
                    sums[i] = '0;
                end
            end
            ACT_COMPARE: begin
                ans.answer_valid = 1'b1;
                ans.identical    = 1'b1;
                for (int i = 0; i < NUM_POINTS; i++) begin
                    if ((64'(prods[0][i]) % m) != (64'(prods[1][i]) % m)) begin
                        ans.identical = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        answers_due.push_back(ans);
    endtask

    always @(posedge aclk) begin
        m_item_t want;
        if (!aresetn) begin
            modulus = MODULUS_RESET;
            for (int i = 0; i < NUM_POINTS; i++) begin
                points[i]   = '0;
                sums[i]     = '0;
                prods[0][i] = MOD_W'(1);
                prods[1][i] = MOD_W'(1);
            end
            answers_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected answer %b/%b", $time,
                             m_data.answer_valid, m_data.identical);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.answer_valid !== m_data.answer_valid) begin
                        $display("%0t: answer_valid expected %b actual %b", $time,
                                 want.answer_valid, m_data.answer_valid);
                        errors++;
                    end
                    if (want.identical !== m_data.identical) begin
                        $display("%0t: identical expected %b actual %b", $time,
                                 want.identical, m_data.identical);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                modulus = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                predict_answer(s_data);
            end
        end
        answers_pending = answers_due.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for the polynomial identity evaluator: clock, reset, stimulus and verdict.
// Depends on pime_pkg, poly_identity_mod_eval_unit and pime_identity_checker.
`timescale 1ns / 100ps

module tb;
    import pime_pkg::*;

    localparam logic [2:0] ACT_SPARE = 3'd5;

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [MOD_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    s_item_t          s_data;
    logic             m_valid;
    logic             m_ready;
    m_item_t          m_data;
    int               errors;
    int               answers_pending;
    bit               calm;
    int               n_items;
    int               n_terms;
    int               n_compares;
    int               n_settings;
    s_item_t          round_items [$];

    poly_identity_mod_eval_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    pime_identity_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .errors          (errors),
        .answers_pending (answers_pending)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
    end

    function automatic s_item_t random_item(logic [2:0] action);
        s_item_t it;
        it.action         = action;
        it.side           = 1'($urandom_range(1));
        it.point_index    = 5'($urandom_range(NUM_POINTS - 1));
        it.point_value    = MOD_W'($urandom_range(1073741822));
        it.coef_negative  = 1'($urandom_range(1));
        it.coef_magnitude = $urandom;
        it.exponent       = $urandom_range(1) ? $urandom : $urandom_range(9);
        return it;
    endfunction

    function automatic s_item_t term_item(logic neg, logic [COEF_W-1:0] mag,
                                          logic [EXP_W-1:0] e);
        s_item_t it;
        it = random_item(ACT_TERM);
        it.coef_negative  = neg;
        it.coef_magnitude = mag;
        it.exponent       = e;
        return it;
    endfunction

    function automatic s_item_t side_item(logic [2:0] action, logic side);
        s_item_t it;
        it = random_item(action);
        it.side = side;
        return it;
    endfunction

    task automatic send(input s_item_t it);
        while (!calm && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        n_items++;
        if (it.action == ACT_TERM) begin
            n_terms++;
        end
        if (it.action == ACT_COMPARE) begin
            n_compares++;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (answers_pending != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_modulus(input logic [MOD_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        n_settings++;
        @(posedge aclk);
    endtask

    task automatic noise();
        int pick;
        pick = $urandom_range(4);
        case (pick)
            0: send(random_item(ACT_LOAD));
            1: send(random_item(ACT_SPARE + 3'($urandom_range(2))));
            2: send(random_item(ACT_COMPARE));
            3: send(random_item(ACT_CLOSE));
            default: send(random_item(ACT_START));
        endcase
    endtask

    task automatic identity_round();
        int      nf;
        bit      match;
        int      k;
        s_item_t it;
        round_items.delete();
        nf = $urandom_range(1, 2);
        match = 1'($urandom_range(1));
        round_items.push_back(side_item(ACT_START, 1'b0));
        for (int f = 0; f < nf; f++) begin
            round_items.push_back(random_item(ACT_TERM));
            if ($urandom_range(3) == 0) begin
                round_items.push_back(random_item(ACT_TERM));
            end
            round_items.push_back(side_item(ACT_CLOSE, 1'b0));
        end
        foreach (round_items[i]) begin
            if ($urandom_range(99) < 12) begin
                noise();
            end
            send(round_items[i]);
        end
        if (!match) begin
            k = 1;
            round_items[k].coef_magnitude ^= COEF_W'($urandom_range(1, 255));
        end
        foreach (round_items[i]) begin
            it = round_items[i];
            it.side = 1'b1;
            send(it);
        end
        send(random_item(ACT_COMPARE));
        if ($urandom_range(1)) begin
            noise();
        end
    endtask

    initial begin
        logic [MOD_W-1:0] settings [5];
        s_item_t          it;
        settings = '{30'h3FFF_FFFF, 30'd0, 30'd101, 30'd2, MODULUS_RESET};
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        calm       = 1'b0;
        n_items    = 0;
        n_terms    = 0;
        n_compares = 0;
        n_settings = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_POINTS; i++) begin
            it = random_item(ACT_LOAD);
            it.point_index = 5'(i);
            if (i == 0) begin
                it.point_value = '0;
            end else if (i == 1) begin
                it.point_value = 30'd1073741822;
            end else if (i == 2) begin
                it.point_value = 30'd1;
            end
            send(it);
        end
        send(random_item(ACT_COMPARE));
        send(side_item(ACT_START, 1'b0));
        send(term_item(1'b0, '1, '1));
        send(term_item(1'b1, '0, '0));
        send(term_item(1'b1, 32'd5, '0));
        send(side_item(ACT_CLOSE, 1'b0));
        send(side_item(ACT_START, 1'b1));
        send(term_item(1'b0, '1, '1));
        send(term_item(1'b1, 32'd5, '0));
        send(side_item(ACT_CLOSE, 1'b1));
        send(random_item(ACT_COMPARE));
        for (int a = 0; a < 3; a++) begin
            send(random_item(ACT_SPARE + 3'(a)));
        end
        send(side_item(ACT_CLOSE, 1'b0));
        send(random_item(ACT_COMPARE));

        for (int p = 0; p <= 5; p++) begin
            if (p > 0) begin
                set_modulus(settings[p-1]);
            end
            calm = (p == 3);
            repeat ((p % 2 == 1) ? 2 : 1) identity_round();
        end
        drain();

        $display("Covered %0d transactions: %0d terms and %0d compares,", n_items, n_terms,
                 n_compares);
        $display("over %0d modulus settings including the smallest and largest.", n_settings);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("tb: failure");
        $finish;
    end

endmodule
